// ===== hdl/ssc_pkg.sv =====
// Shared types, constants and helpers of the selector safety checker.
package ssc_pkg;

    localparam int BUDGET_BITS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int LEN_W   = 17;
    localparam int MAXL_W  = 16;
    localparam int COUNT_W = 14;
    localparam int SHEET_W = 20;
    localparam int DECL_W  = 8;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 2;

    localparam logic [LEN_W-1:0]   LEN_SAT   = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] COUNT_SAT = 14'h3FFF;

    localparam logic [MAXL_W-1:0]  RST_MAX_LEN   = 16'd4096;
    localparam logic [COUNT_W-1:0] RST_MAX_TOTAL = 14'd8192;
    localparam logic [SHEET_W-1:0] RST_MAX_SHEET = 20'd524288;
    localparam logic [DECL_W-1:0]  RST_DECL_LEN  = 8'd26;

    localparam logic [IDX_W-1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_MAX_TOTAL = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_SHEET = 2'd2;
    localparam logic [IDX_W-1:0] CFG_DECL_LEN  = 2'd3;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_EMPTY,
        FAULT_LONG,
        FAULT_UTF8,
        FAULT_COMMENT,
        FAULT_FORBIDDEN,
        FAULT_COUNT,
        FAULT_BUDGET
    } fault_t;

    typedef struct packed {
        logic [MAXL_W-1:0]  max_len;
        logic [COUNT_W-1:0] max_total;
        logic [SHEET_W-1:0] max_sheet;
        logic [DECL_W-1:0]  decl_len;
    } cfg_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        fault_t           fault;
        logic             last;
    } sel_rec_t;

    function automatic fault_t fault_merge(input fault_t cur, input fault_t code);
        fault_t res;
        res = cur;
        if (cur == FAULT_NONE || code < cur)
        begin
            res = code;
        end
        return res;
    endfunction

endpackage

// ===== hdl/ssc_front.sv =====
// Front end: per-byte UTF-8, length, comment and character checks of one selector.
module ssc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  ssc_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              byte_present,
    input  logic              selector_end,
    input  logic              list_end,
    input  logic              q_full,
    output logic              q_push,
    output ssc_pkg::sel_rec_t q_rec
);
    import ssc_pkg::*;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    logic [1:0]       pend_reg,   pend_next;
    logic [2:0]       width_reg,  width_next;
    logic [20:0]      acc_reg,    acc_next;
    logic [LEN_W-1:0] len_reg,    len_next;
    logic             slash_reg,  slash_next;
    logic             star_reg,   star_next;
    fault_t           fault_reg,  fault_next;

    logic [LEN_W-1:0] len_b;
    logic [1:0]       pend_b;
    fault_t           fault_b;
    fault_t           end_fault;
    logic [20:0]      lowest;
    logic             accept;
    logic             closing;
    logic             bad_char;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign closing  = selector_end || list_end;

    always_comb
    begin
        len_b      = len_reg;
        pend_b     = pend_reg;
        width_next = width_reg;
        acc_next   = acc_reg;
        fault_b    = fault_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        lowest     = 21'h10000;
        bad_char   = 1'b0;
        if (byte_present)
        begin
            if (len_reg != LEN_SAT)
            begin
                len_b = len_reg + LEN_W'(1);
            end
            if (pend_reg == 2'd0)
            begin
                if (!data_byte[7])
                begin
                    pend_b = 2'd0;
                end
                else if (data_byte[7:5] == 3'b110)
                begin
                    width_next = 3'd2;
                    acc_next   = {16'd0, data_byte[4:0]};
                    pend_b     = 2'd1;
                end
                else if (data_byte[7:4] == 4'b1110)
                begin
                    width_next = 3'd3;
                    acc_next   = {17'd0, data_byte[3:0]};
                    pend_b     = 2'd2;
                end
                else if (data_byte[7:3] == 5'b11110)
                begin
                    width_next = 3'd4;
                    acc_next   = {18'd0, data_byte[2:0]};
                    pend_b     = 2'd3;
                end
                else
                begin
                    fault_b = fault_merge(fault_b, FAULT_UTF8);
                end
            end
            else if (data_byte[7:6] != 2'b10)
            begin
                fault_b = fault_merge(fault_b, FAULT_UTF8);
                pend_b  = 2'd0;
            end
            else
            begin
                acc_next = {acc_reg[14:0], data_byte[5:0]};
                pend_b   = pend_reg - 2'd1;
                if (width_reg == 3'd2)
                begin
                    lowest = 21'h80;
                end
                else if (width_reg == 3'd3)
                begin
                    lowest = 21'h800;
                end
                if (pend_b == 2'd0 &&
                    (acc_next < lowest || acc_next > 21'h10FFFF ||
                     (acc_next >= 21'hD800 && acc_next <= 21'hDFFF)))
                begin
                    fault_b = fault_merge(fault_b, FAULT_UTF8);
                end
            end
            if ((slash_reg && data_byte == CH_STAR) || (star_reg && data_byte == CH_SLASH))
            begin
                fault_b = fault_merge(fault_b, FAULT_COMMENT);
            end
            slash_next = (data_byte == CH_SLASH);
            star_next  = (data_byte == CH_STAR);
            case (data_byte)
                8'h7F, 8'h7B, 8'h7D, 8'h3C, 8'h3E, 8'h40, 8'h3B, 8'h60: bad_char = 1'b1;
                default: bad_char = (data_byte < 8'h20);
            endcase
            if (bad_char)
            begin
                fault_b = fault_merge(fault_b, FAULT_FORBIDDEN);
            end
        end

        if (len_b == '0)
        begin
            end_fault = FAULT_EMPTY;
        end
        else if (len_b > LEN_W'(cfg.max_len))
        begin
            end_fault = FAULT_LONG;
        end
        else if (pend_b != 2'd0)
        begin
            end_fault = FAULT_UTF8;
        end
        else
        begin
            end_fault = fault_b;
        end

        len_next   = len_b;
        pend_next  = pend_b;
        fault_next = fault_b;
        if (closing)
        begin
            len_next   = '0;
            pend_next  = '0;
            width_next = '0;
            acc_next   = '0;
            slash_next = 1'b0;
            star_next  = 1'b0;
            fault_next = FAULT_NONE;
        end
    end

    assign q_push     = accept && closing;
    assign q_rec.len   = len_b;
    assign q_rec.fault = end_fault;
    assign q_rec.last  = list_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            width_reg <= '0;
            acc_reg   <= '0;
            len_reg   <= '0;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
            fault_reg <= FAULT_NONE;
        end
        else if (accept)
        begin
            pend_reg  <= pend_next;
            width_reg <= width_next;
            acc_reg   <= acc_next;
            len_reg   <= len_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
            fault_reg <= fault_next;
        end
    end

endmodule

// ===== hdl/ssc_queue.sv =====
// Short queue of closed-selector records between front and back.
module ssc_queue
#(
    parameter int DEPTH = ssc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ssc_pkg::sel_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output ssc_pkg::sel_rec_t head
);
    import ssc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sel_rec_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign valid   = (cnt_reg != '0);
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_rec;
        end
    end

endmodule

// ===== hdl/ssc_back.sv =====
// Back end: list count and budget accounting, result register.
module ssc_back
#(
    parameter int BUDGET_BITS = ssc_pkg::BUDGET_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  ssc_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  ssc_pkg::sel_rec_t             q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          selector_ok,
    output logic [2:0]                    fault_code,
    output logic                          list_ok,
    output logic [ssc_pkg::COUNT_W-1:0]   selector_count,
    output logic [ssc_pkg::SHEET_W-1:0]   sheet_bytes,
    output logic                          list_done
);
    import ssc_pkg::*;

    localparam int SUM_W = ((BUDGET_BITS > LEN_W) ? BUDGET_BITS : LEN_W) + 2;
    localparam int CMP_W = (SUM_W > SHEET_W) ? SUM_W : SHEET_W;
    localparam int OUT_W = (BUDGET_BITS > SHEET_W) ? BUDGET_BITS : SHEET_W;

    logic [COUNT_W-1:0]     count_reg, count_next, count_new;
    logic [BUDGET_BITS-1:0] bytes_reg, bytes_next, bytes_new;
    logic                   failed_reg, failed_next, failed_new;
    logic                   ovalid_reg, ovalid_next;
    fault_t                 fault_reg, fault_new;
    logic                   lok_reg;
    logic [COUNT_W-1:0]     ocount_reg;
    logic [OUT_W-1:0]       obytes_reg;
    logic                   done_reg;
    logic [SUM_W-1:0]       total;

    assign q_pop = q_valid && (!ovalid_reg || out_ready);

    always_comb
    begin
        fault_new = q_head.fault;
        if (fault_new == FAULT_NONE && count_reg >= cfg.max_total)
        begin
            fault_new = FAULT_COUNT;
        end
        count_new = (count_reg != COUNT_SAT) ? count_reg + COUNT_W'(1) : count_reg;
        total = SUM_W'(bytes_reg) + SUM_W'(q_head.len) + SUM_W'(cfg.decl_len);
        if (fault_new == FAULT_NONE && CMP_W'(total) > CMP_W'(cfg.max_sheet))
        begin
            fault_new = FAULT_BUDGET;
        end
        failed_new = failed_reg;
        bytes_new  = bytes_reg;
        if (fault_new != FAULT_NONE)
        begin
            failed_new = 1'b1;
        end
        else if (!failed_reg)
        begin
            bytes_new = total[BUDGET_BITS-1:0];
        end

        count_next  = count_reg;
        bytes_next  = bytes_reg;
        failed_next = failed_reg;
        ovalid_next = ovalid_reg && !out_ready;
        if (q_pop)
        begin
            ovalid_next = 1'b1;
            if (q_head.last)
            begin
                count_next  = '0;
                bytes_next  = '0;
                failed_next = 1'b0;
            end
            else
            begin
                count_next  = count_new;
                bytes_next  = bytes_new;
                failed_next = failed_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            bytes_reg  <= '0;
            failed_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            bytes_reg  <= bytes_next;
            failed_reg <= failed_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            fault_reg  <= fault_new;
            lok_reg    <= !failed_new;
            ocount_reg <= count_new;
            obytes_reg <= OUT_W'(bytes_new);
            done_reg   <= q_head.last;
        end
    end

    assign out_valid      = ovalid_reg;
    assign selector_ok    = (fault_reg == FAULT_NONE);
    assign fault_code     = fault_reg;
    assign list_ok        = lok_reg;
    assign selector_count = ocount_reg;
    assign sheet_bytes    = obytes_reg[SHEET_W-1:0];
    assign list_done      = done_reg;

endmodule

// ===== hdl/selector_safety_checker.sv =====
// Top level of the selector safety checker: configuration registers and the front/back split.
//
//  channel   direction  handshake              payload
//  in        in         in_valid / in_ready    data_byte, byte_present, selector_end, list_end
//  out       out        out_valid / out_ready  selector_ok, fault_code, list_ok,
//                                              selector_count, sheet_bytes, list_done
//  cfg       in         cfg_write              cfg_index, cfg_data
//
// One byte transfer per cycle while in_ready is high; the front checks each byte in
// the cycle it is taken. A closing record passes the record queue and then the result
// register to out. One result per cycle while out_ready is high, set by the back end.
// in_ready drops only while the record queue is full; out stalls fill it.
// Reset clears all selector and list state and loads the default limits.
module selector_safety_checker
#(
    parameter int BUDGET_BITS = ssc_pkg::BUDGET_BITS_DEF,
    parameter int QUEUE_DEPTH = ssc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [ssc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ssc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         byte_present,
    input  logic                         selector_end,
    input  logic                         list_end,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         selector_ok,
    output logic [2:0]                   fault_code,
    output logic                         list_ok,
    output logic [ssc_pkg::COUNT_W-1:0]  selector_count,
    output logic [ssc_pkg::SHEET_W-1:0]  sheet_bytes,
    output logic                         list_done
);
    import ssc_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    sel_rec_t push_rec;
    sel_rec_t head_rec;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MAX_LEN:   cfg_next.max_len   = cfg_data[MAXL_W-1:0];
                CFG_MAX_TOTAL: cfg_next.max_total = cfg_data[COUNT_W-1:0];
                CFG_MAX_SHEET: cfg_next.max_sheet = cfg_data[SHEET_W-1:0];
                CFG_DECL_LEN:  cfg_next.decl_len  = cfg_data[DECL_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_len   <= RST_MAX_LEN;
            cfg_reg.max_total <= RST_MAX_TOTAL;
            cfg_reg.max_sheet <= RST_MAX_SHEET;
            cfg_reg.decl_len  <= RST_DECL_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ssc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .selector_end (selector_end),
        .list_end     (list_end),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_rec        (push_rec)
    );

    ssc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_rec)
    );

    ssc_back #(.BUDGET_BITS(BUDGET_BITS)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_head         (head_rec),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .selector_ok    (selector_ok),
        .fault_code     (fault_code),
        .list_ok        (list_ok),
        .selector_count (selector_count),
        .sheet_bytes    (sheet_bytes),
        .list_done      (list_done)
    );

endmodule

// ===== hdl/ssc_checker.sv =====
// Port-level assertions of the selector safety checker and their bind.
module ssc_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_write,
    input logic [ssc_pkg::IDX_W-1:0]    cfg_index,
    input logic [ssc_pkg::CFG_W-1:0]    cfg_data,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic [7:0]                   data_byte,
    input logic                         byte_present,
    input logic                         selector_end,
    input logic                         list_end,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         selector_ok,
    input logic [2:0]                   fault_code,
    input logic                         list_ok,
    input logic [ssc_pkg::COUNT_W-1:0]  selector_count,
    input logic [ssc_pkg::SHEET_W-1:0]  sheet_bytes,
    input logic                         list_done
);
    import ssc_pkg::*;

    a_reset_idle: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (selector_ok == (fault_code == FAULT_NONE)))
        else $error("selector_ok disagrees with fault_code");

    a_fail_rejects_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !selector_ok |-> !list_ok)
        else $error("failing selector left list_ok high");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> selector_count != '0)
        else $error("result shows zero selectors");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(fault_code) && $stable(sheet_bytes))
        else $error("stalled result changed");

endmodule

bind selector_safety_checker ssc_checker u_ssc_checker (.*);

// ===== sim/selector_verdict_checker.sv =====
`timescale 1ns / 100ps
// Verdict checker: predicts each closed selector's result from the input transfers and compares.
module selector_verdict_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [ssc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ssc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [7:0]                   data_byte,
    input  logic                         byte_present,
    input  logic                         selector_end,
    input  logic                         list_end,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         selector_ok,
    input  logic [2:0]                   fault_code,
    input  logic                         list_ok,
    input  logic [ssc_pkg::COUNT_W-1:0]  selector_count,
    input  logic [ssc_pkg::SHEET_W-1:0]  sheet_bytes,
    input  logic                         list_done,
    output int                           mismatches,
    output int                           pending
);

    import ssc_pkg::*;

    localparam logic [7:0] TICK_CHAR = 8'h60;
    localparam logic [7:0] DEL_CHAR  = 8'h7F;

    typedef struct packed {
        logic               ok;
        fault_t             code;
        logic               list_ok;
        logic [COUNT_W-1:0] count;
        logic [SHEET_W-1:0] charged;
        logic               done;
    } verdict_t;

    verdict_t verdicts[$];
    verdict_t want;

    cfg_t               limits;
    logic [1:0]         cont_due;
    logic [2:0]         seq_width;
    logic [20:0]        code_point;
    logic [LEN_W-1:0]   run_len;
    logic               after_slash;
    logic               after_star;
    fault_t             byte_fault;
    logic [COUNT_W-1:0] closed_count;
    logic [SHEET_W-1:0] charged;
    logic               list_bad;

    task flag_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task compare_field(input string name, input logic [31:0] exp_val, input logic [31:0] got);
        if (got !== exp_val)
        begin
            flag_mismatch($sformatf("%s expected %0d, got %0d", name, exp_val, got));
        end
    endtask

    task flag_fault(input fault_t code);
        if (byte_fault == FAULT_NONE || code < byte_fault)
        begin
            byte_fault = code;
        end
    endtask

    task restart_selector();
        cont_due    = '0;
        seq_width   = '0;
        code_point  = '0;
        run_len     = '0;
        after_slash = 1'b0;
        after_star  = 1'b0;
        byte_fault  = FAULT_NONE;
    endtask

    task absorb_byte(input logic [7:0] b);
        logic [20:0] floor_cp;
        if (run_len != LEN_SAT)
        begin
            run_len = run_len + 1'b1;
        end
        if (cont_due == 2'd0)
        begin
            if (b[7:5] == 3'b110)
            begin
                seq_width  = 3'd2;
                code_point = {16'd0, b[4:0]};
                cont_due   = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_width  = 3'd3;
                code_point = {17'd0, b[3:0]};
                cont_due   = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                seq_width  = 3'd4;
                code_point = {18'd0, b[2:0]};
                cont_due   = 2'd3;
            end
            else if (b[7])
            begin
                flag_fault(FAULT_UTF8);
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            flag_fault(FAULT_UTF8);
            cont_due = 2'd0;
        end
        else
        begin
            code_point = {code_point[14:0], b[5:0]};
            cont_due   = cont_due - 1'b1;
            if (cont_due == 2'd0)
            begin
                floor_cp = (seq_width == 3'd2) ? 21'h80 :
                           (seq_width == 3'd3) ? 21'h800 : 21'h10000;
                if (code_point < floor_cp || code_point > 21'h10FFFF ||
                    (code_point >= 21'hD800 && code_point <= 21'hDFFF))
                begin
                    flag_fault(FAULT_UTF8);
                end
            end
        end
        if ((after_slash && b == "*") || (after_star && b == "/"))
        begin
            flag_fault(FAULT_COMMENT);
        end
        after_slash = (b == "/");
        after_star  = (b == "*");
        if (b < 8'h20 || b == DEL_CHAR || b == "{" || b == "}" || b == "<" ||
            b == ">" || b == "@" || b == ";" || b == TICK_CHAR)
        begin
            flag_fault(FAULT_FORBIDDEN);
        end
    endtask

    task close_selector(input logic last);
        fault_t      code;
        logic [21:0] total;
        verdict_t    v;
        if (run_len == '0)
        begin
            code = FAULT_EMPTY;
        end
        else if (run_len > {1'b0, limits.max_len})
        begin
            code = FAULT_LONG;
        end
        else if (cont_due != 2'd0)
        begin
            code = FAULT_UTF8;
        end
        else
        begin
            code = byte_fault;
        end
        if (code == FAULT_NONE && closed_count >= limits.max_total)
        begin
            code = FAULT_COUNT;
        end
        if (closed_count != COUNT_SAT)
        begin
            closed_count = closed_count + 1'b1;
        end
        total = {2'b00, charged} + {5'd0, run_len} + {14'd0, limits.decl_len};
        if (code == FAULT_NONE && total > {2'b00, limits.max_sheet})
        begin
            code = FAULT_BUDGET;
        end
        if (code != FAULT_NONE)
        begin
            list_bad = 1'b1;
        end
        else if (!list_bad)
        begin
            charged = total[SHEET_W-1:0];
        end
        v.ok      = (code == FAULT_NONE);
        v.code    = code;
        v.list_ok = !list_bad;
        v.count   = closed_count;
        v.charged = charged;
        v.done    = last;
        verdicts.push_back(v);
        restart_selector();
        if (last)
        begin
            closed_count = '0;
            charged      = '0;
            list_bad     = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits.max_len   = RST_MAX_LEN;
            limits.max_total = RST_MAX_TOTAL;
            limits.max_sheet = RST_MAX_SHEET;
            limits.decl_len  = RST_DECL_LEN;
            restart_selector();
            closed_count = '0;
            charged      = '0;
            list_bad     = 1'b0;
            verdicts.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MAX_LEN:   limits.max_len   = cfg_data[MAXL_W-1:0];
                    CFG_MAX_TOTAL: limits.max_total = cfg_data[COUNT_W-1:0];
                    CFG_MAX_SHEET: limits.max_sheet = cfg_data[SHEET_W-1:0];
                    CFG_DECL_LEN:  limits.decl_len  = cfg_data[DECL_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (byte_present)
                begin
                    absorb_byte(data_byte);
                end
                if (selector_end || list_end)
                begin
                    close_selector(list_end);
                end
            end
            if (out_valid && out_ready)
            begin
                if (verdicts.size() == 0)
                begin
                    flag_mismatch("result transfer with no selector closed");
                end
                else
                begin
                    want = verdicts.pop_front();
                    compare_field("selector_ok", 32'(want.ok), 32'(selector_ok));
                    compare_field("fault_code", 32'(want.code), 32'(fault_code));
                    compare_field("list_ok", 32'(want.list_ok), 32'(list_ok));
                    compare_field("selector_count", 32'(want.count), 32'(selector_count));
                    compare_field("sheet_bytes", 32'(want.charged), 32'(sheet_bytes));
                    compare_field("list_done", 32'(want.done), 32'(list_done));
                end
            end
            pending = verdicts.size();
        end
    end

endmodule

// ===== sim/tb_selector_safety_checker.sv =====
`timescale 1ns / 100ps
// Testbench top: drives selector lists and limit settings, and gives the verdict.
module tb_selector_safety_checker;

    import ssc_pkg::*;

    localparam int         ITEMS_GOAL   = 1400;
    localparam int         PHASE_ITEMS  = 140;
    localparam int         LIMIT_CYCLES = 3_000_000;
    localparam logic [7:0] TICK_CHAR    = 8'h60;
    localparam string      SAFE_CHARS   = "abcdefxyzABCXYZ0129 .#-_:[]=()+~,!|^$%&?\"'";
    localparam string      BAD_CHARS    = "{}<>@;";

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_PERIODIC} rx_mode_t;

    typedef enum int {
        FLAW_FORBIDDEN,
        FLAW_COMMENT,
        FLAW_OVERLONG,
        FLAW_SURROGATE,
        FLAW_TOO_HIGH,
        FLAW_TRUNCATED,
        FLAW_BROKEN,
        FLAW_STRAY,
        FLAW_NOISE,
        FLAW_BAD_LEAD
    } flaw_t;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_write    = 1'b0;
    logic [IDX_W-1:0]    cfg_index    = CFG_MAX_LEN;
    logic [CFG_W-1:0]    cfg_data     = '0;
    logic                in_valid     = 1'b0;
    logic                in_ready;
    logic [7:0]          data_byte    = '0;
    logic                byte_present = 1'b0;
    logic                selector_end = 1'b0;
    logic                list_end     = 1'b0;
    logic                out_valid;
    logic                out_ready    = 1'b0;
    logic                selector_ok;
    logic [2:0]          fault_code;
    logic                list_ok;
    logic [COUNT_W-1:0]  selector_count;
    logic [SHEET_W-1:0]  sheet_bytes;
    logic                list_done;
    int                  mismatches;
    int                  pending;

    logic [7:0] sel_bytes[$];
    int         burst_left = 0;
    int         items_sent = 0;
    rx_mode_t   rx_mode    = RX_OPEN;
    int         rx_left    = 0;

    selector_safety_checker i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .selector_end   (selector_end),
        .list_end       (list_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .selector_ok    (selector_ok),
        .fault_code     (fault_code),
        .list_ok        (list_ok),
        .selector_count (selector_count),
        .sheet_bytes    (sheet_bytes),
        .list_done      (list_done)
    );

    selector_verdict_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .selector_end   (selector_end),
        .list_end       (list_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .selector_ok    (selector_ok),
        .fault_code     (fault_code),
        .list_ok        (list_ok),
        .selector_count (selector_count),
        .sheet_bytes    (sheet_bytes),
        .list_done      (list_done),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            RX_CHOKE: out_ready <= ($urandom_range(0, 7) == 0);
            default:  out_ready <= ((rx_left % 8) < 5);
        endcase
    end

    task send_item(input logic [7:0] b, input logic present, input logic sel_end,
                   input logic lst_end);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 40);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= present;
        selector_end <= sel_end;
        list_end     <= lst_end;
        if (present || sel_end || lst_end)
        begin
            items_sent++;
        end
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // drop valid, wait for every expected result, then let the pipeline empty
    task settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task add_code_point(input int cp);
        if (cp < 'h80)
        begin
            sel_bytes.push_back(cp[7:0]);
        end
        else if (cp < 'h800)
        begin
            sel_bytes.push_back(8'hC0 | cp[10:6]);
            sel_bytes.push_back(8'h80 | cp[5:0]);
        end
        else if (cp < 'h10000)
        begin
            sel_bytes.push_back(8'hE0 | cp[15:12]);
            sel_bytes.push_back(8'h80 | cp[11:6]);
            sel_bytes.push_back(8'h80 | cp[5:0]);
        end
        else
        begin
            sel_bytes.push_back(8'hF0 | cp[20:18]);
            sel_bytes.push_back(8'h80 | cp[17:12]);
            sel_bytes.push_back(8'h80 | cp[11:6]);
            sel_bytes.push_back(8'h80 | cp[5:0]);
        end
    endtask

    task add_clean_char();
        int cp;
        case ($urandom_range(0, 9))
            0: cp = $urandom_range('h80, 'h7FF);
            1:
            begin
                cp = $urandom_range('h800, 'hFFFF);
                if (cp >= 'hD800 && cp <= 'hDFFF)
                begin
                    cp = cp - 'h1000;
                end
            end
            2: cp = $urandom_range('h10000, 'h10FFFF);
            default: cp = SAFE_CHARS[$urandom_range(0, SAFE_CHARS.len() - 1)];
        endcase
        add_code_point(cp);
    endtask

    task add_flaw(input flaw_t flaw);
        int w;
        case (flaw)
            FLAW_FORBIDDEN:
            begin
                case ($urandom_range(0, 3))
                    0: sel_bytes.push_back(BAD_CHARS[$urandom_range(0, BAD_CHARS.len() - 1)]);
                    1: sel_bytes.push_back(TICK_CHAR);
                    2: sel_bytes.push_back(8'h7F);
                    default: sel_bytes.push_back(8'($urandom_range(0, 'h1F)));
                endcase
            end
            FLAW_COMMENT:
            begin
                if ($urandom_range(0, 1))
                begin
                    sel_bytes.push_back("/");
                    sel_bytes.push_back("*");
                end
                else
                begin
                    sel_bytes.push_back("*");
                    sel_bytes.push_back("/");
                end
            end
            FLAW_OVERLONG:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        sel_bytes.push_back(8'($urandom_range('hC0, 'hC1)));
                        sel_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                    end
                    1:
                    begin
                        sel_bytes.push_back(8'hE0);
                        sel_bytes.push_back(8'($urandom_range('h80, 'h9F)));
                        sel_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                    end
                    default:
                    begin
                        sel_bytes.push_back(8'hF0);
                        sel_bytes.push_back(8'($urandom_range('h80, 'h8F)));
                        sel_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                        sel_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                    end
                endcase
            end
            FLAW_SURROGATE: add_code_point($urandom_range('hD800, 'hDFFF));
            FLAW_TOO_HIGH:  add_code_point($urandom_range('h110000, 'h1FFFFF));
            FLAW_TRUNCATED, FLAW_BROKEN:
            begin
                w = $urandom_range(2, 4);
                if (w == 2)
                begin
                    sel_bytes.push_back(8'($urandom_range('hC2, 'hDF)));
                end
                else if (w == 3)
                begin
                    sel_bytes.push_back(8'($urandom_range('hE1, 'hEC)));
                end
                else
                begin
                    sel_bytes.push_back(8'($urandom_range('hF1, 'hF3)));
                end
                repeat ($urandom_range(0, w - 2))
                begin
                    sel_bytes.push_back(8'($urandom_range('h80, 'hBF)));
                end
                if (flaw == FLAW_BROKEN)
                begin
                    sel_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range('h21, 'h7E) :
                                                                  $urandom_range('hC2, 'hF4)));
                end
            end
            FLAW_STRAY: sel_bytes.push_back(8'($urandom_range('h80, 'hBF)));
            FLAW_NOISE:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    sel_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
            default: sel_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
        endcase
    endtask

    task build_selector();
        int    lead;
        int    tail;
        flaw_t flaw;
        sel_bytes.delete();
        lead = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
        tail = $urandom_range(0, 4);
        repeat (lead) add_clean_char();
        if ($urandom_range(0, 9) < 4)
        begin
            flaw = flaw_t'($urandom_range(0, int'(FLAW_BAD_LEAD)));
            add_flaw(flaw);
            if (flaw == FLAW_TRUNCATED)
            begin
                tail = 0;
            end
        end
        repeat (tail) add_clean_char();
        if (sel_bytes.size() == 0)
        begin
            add_clean_char();
        end
    endtask

    task emit_selector(input logic last);
        int   i;
        logic split;
        logic both;
        split = (sel_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
        both  = 1'($urandom_range(0, 1));
        for (i = 0; i < sel_bytes.size(); i++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0);
            end
            if (!split && i == sel_bytes.size() - 1)
            begin
                send_item(sel_bytes[i], 1'b1, !last || both, last);
            end
            else
            begin
                send_item(sel_bytes[i], 1'b1, 1'b0, 1'b0);
            end
        end
        if (split)
        begin
            send_item(8'($urandom_range(0, 255)), 1'b0, !last || both, last);
        end
    endtask

    task run_list();
        int n;
        int k;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                sel_bytes.delete();
            end
            else
            begin
                build_selector();
            end
            emit_selector(k == n - 1);
        end
    endtask

    initial
    begin
        #(LIMIT_CYCLES * 12);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int               phase;
        int               phase_end;
        logic [CFG_W-1:0] len_lim;
        logic [CFG_W-1:0] total_lim;
        logic [CFG_W-1:0] sheet_lim;
        logic [CFG_W-1:0] decl_lim;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset limits, one list of corner cases
        send_item("a", 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0, 1'b0);
        send_item("/", 1'b1, 1'b0, 1'b0);
        send_item("*", 1'b1, 1'b1, 1'b0);
        send_item("*", 1'b1, 1'b0, 1'b0);
        send_item("/", 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1, 1'b0);
        send_item("{", 1'b1, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b0, 1'b0);
        send_item(8'hA9, 1'b1, 1'b1, 1'b0);
        send_item(8'hC0, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hED, 1'b1, 1'b0, 1'b0);
        send_item(8'hA0, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hF4, 1'b1, 1'b0, 1'b0);
        send_item(8'h90, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b1, 1'b0);
        send_item(8'hC3, 1'b1, 1'b0, 1'b0);
        send_item("A", 1'b1, 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b1);
        settle();

        phase = 0;
        while (items_sent < ITEMS_GOAL)
        begin
            case (phase)
                0:
                begin
                    len_lim   = CFG_W'(RST_MAX_LEN);
                    total_lim = CFG_W'(RST_MAX_TOTAL);
                    sheet_lim = CFG_W'(RST_MAX_SHEET);
                    decl_lim  = CFG_W'(RST_DECL_LEN);
                end
                1:
                begin
                    len_lim   = 3;
                    total_lim = 2;
                    sheet_lim = 40;
                    decl_lim  = 0;
                end
                2:
                begin
                    len_lim   = 65535;
                    total_lim = 16383;
                    sheet_lim = 1048575;
                    decl_lim  = 255;
                end
                3:
                begin
                    len_lim   = 1;
                    total_lim = 1;
                    sheet_lim = 1;
                    decl_lim  = 255;
                end
                4:
                begin
                    len_lim   = 0;
                    total_lim = 0;
                    sheet_lim = 0;
                    decl_lim  = 0;
                end
                default:
                begin
                    len_lim   = CFG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 16) :
                                                                    $urandom_range(1, 65535));
                    total_lim = CFG_W'($urandom_range(0, 1) ? $urandom_range(1, 8) :
                                                              $urandom_range(1, 16383));
                    sheet_lim = CFG_W'($urandom_range(0, 1) ? $urandom_range(30, 400) :
                                                              $urandom_range(1, 1048575));
                    decl_lim  = CFG_W'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_MAX_LEN, len_lim);
            write_reg(CFG_MAX_TOTAL, total_lim);
            write_reg(CFG_MAX_SHEET, sheet_lim);
            write_reg(CFG_DECL_LEN, decl_lim);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                run_list();
            end
            settle();
            phase++;
        end

        repeat (10) @(negedge clk);

        if (mismatches == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
